>>> rtl/core/hkse_pkg.sv
package hkse_pkg;

    localparam int OPCODE_W  = 2;
    localparam int KEY_W     = 64;
    localparam int ENTRIES_W = 11;

    // remainder bits folded per cycle when the capacity is not a power of two
    localparam int MOD_STEP  = 8;
    localparam int MOD_CYC_W = $clog2(KEY_W / MOD_STEP);

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [KEY_W-1:0] EMPTY_SUBST = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/hkse_req_if.sv
interface hkse_req_if;
    logic                          valid;
    logic                          ready;
    logic [hkse_pkg::OPCODE_W-1:0] opcode;
    logic [hkse_pkg::KEY_W-1:0]    key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

>>> rtl/core/hkse_rsp_if.sv
interface hkse_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [hkse_pkg::ENTRIES_W-1:0] entries;

    modport source (output valid, output ok, output entries, input ready);
    modport sink   (input valid, input ok, input entries, output ready);
endinterface

>>> rtl/core/hash_key_set_engine_core.sv
// Open-addressed set of 64-bit keys with linear probing over a slot RAM
// of CAPACITY x 64 bits with a read port and a separate write port (0
// marks an empty slot; key 0 is stored as all ones). One word is worked
// on at a time. Insert and lookup take one RAM read and one compare per
// probe, after a start-slot modulo when CAPACITY is not a power of two;
// an insert on a full set, a lookup on an empty set and opcode 3 go
// straight to the result. Clear zeroes one slot per cycle. After reset
// the same clearing pass runs with req.ready low. The result sits in an
// output register, so a new word is taken while the last result waits.
// entries reports the low 11 bits of the stored key count.
module hash_key_set_engine_core #(
    parameter int CAPACITY = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    hkse_req_if.sink     req,
    hkse_rsp_if.source   rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] PRB_LAST = CNT_W'(CAPACITY - 1);
    localparam logic [IDX_W:0]   REM_CAP  = (IDX_W + 1)'(CAPACITY);

    hkse_pkg::state_t state_reg, state_next;

    logic [hkse_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [hkse_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [IDX_W-1:0]              clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              prb_reg, prb_next;
    logic                          clr_report_reg, clr_report_next;
    logic                          pend_ok_reg, pend_ok_next;
    logic [hkse_pkg::KEY_W-1:0]    mod_sh_reg, mod_sh_next;
    logic [IDX_W-1:0]              mod_rem_reg, mod_rem_next;
    logic [hkse_pkg::MOD_CYC_W-1:0] mod_cyc_reg, mod_cyc_next;

    logic                          rsp_valid_reg, rsp_valid_next;
    logic                          rsp_ok_reg, rsp_ok_next;
    logic [hkse_pkg::ENTRIES_W-1:0] rsp_entries_reg, rsp_entries_next;

    logic [hkse_pkg::KEY_W-1:0] slot_mem [CAPACITY];
    logic [hkse_pkg::KEY_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_wa;
    logic [hkse_pkg::KEY_W-1:0] mem_wd;

    logic [hkse_pkg::KEY_W-1:0] key_in;
    logic                       req_fire;
    logic [IDX_W:0]             mod_acc;

    assign req.ready   = (state_reg == hkse_pkg::ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign key_in      = (req.key == '0) ? hkse_pkg::EMPTY_SUBST : req.key;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.ok      = rsp_ok_reg;
    assign rsp.entries = rsp_entries_reg;

    // remainder of key by CAPACITY, MOD_STEP bits per cycle from the MSB
    always_comb
    begin
        mod_acc = {1'b0, mod_rem_reg};
        for (int i = 0; i < hkse_pkg::MOD_STEP; i++)
        begin
            mod_acc = {mod_acc[IDX_W-1:0], mod_sh_reg[hkse_pkg::KEY_W-1-i]};
            if (mod_acc >= REM_CAP)
            begin
                mod_acc = mod_acc - REM_CAP;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        key_next         = key_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        clr_idx_next     = clr_idx_reg;
        cnt_next         = cnt_reg;
        prb_next         = prb_reg;
        clr_report_next  = clr_report_reg;
        pend_ok_next     = pend_ok_reg;
        mod_sh_next      = mod_sh_reg;
        mod_rem_next     = mod_rem_reg;
        mod_cyc_next     = mod_cyc_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_ok_next      = rsp_ok_reg;
        rsp_entries_next = rsp_entries_reg;
        mem_we           = 1'b0;
        mem_wa           = clr_idx_reg;
        mem_wd           = '0;

        case (state_reg)
            hkse_pkg::ST_CLR:
            begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_LAST)
                begin
                    clr_idx_next = '0;
                    pend_ok_next = 1'b1;
                    state_next   = clr_report_reg ? hkse_pkg::ST_DONE : hkse_pkg::ST_IDLE;
                end
            end
            hkse_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    key_next     = key_in;
                    op_next      = req.opcode;
                    prb_next     = '0;
                    pend_ok_next = 1'b0;
                    mod_sh_next  = key_in;
                    mod_rem_next = '0;
                    mod_cyc_next = '0;
                    idx_next     = key_in[IDX_W-1:0];
                    if (req.opcode == hkse_pkg::OP_CLEAR)
                    begin
                        cnt_next        = '0;
                        clr_idx_next    = '0;
                        clr_report_next = 1'b1;
                        state_next      = hkse_pkg::ST_CLR;
                    end
                    else if ((req.opcode == hkse_pkg::OP_INSERT && cnt_reg < CNT_CAP) ||
                             (req.opcode == hkse_pkg::OP_LOOKUP && cnt_reg != '0))
                    begin
                        state_next = IS_POW2 ? hkse_pkg::ST_READ : hkse_pkg::ST_MOD;
                    end
                    else
                    begin
                        state_next = hkse_pkg::ST_DONE;
                    end
                end
            end
            hkse_pkg::ST_MOD:
            begin
                mod_sh_next  = mod_sh_reg << hkse_pkg::MOD_STEP;
                mod_rem_next = mod_acc[IDX_W-1:0];
                mod_cyc_next = mod_cyc_reg + 1'b1;
                if (mod_cyc_reg == '1)
                begin
                    idx_next   = mod_acc[IDX_W-1:0];
                    state_next = hkse_pkg::ST_READ;
                end
            end
            hkse_pkg::ST_READ:
            begin
                state_next = hkse_pkg::ST_CHECK;
            end
            hkse_pkg::ST_CHECK:
            begin
                if (rd_data_reg == key_reg)
                begin
                    pend_ok_next = 1'b1;
                    state_next   = hkse_pkg::ST_DONE;
                end
                else if (rd_data_reg == '0)
                begin
                    if (op_reg == hkse_pkg::OP_INSERT)
                    begin
                        mem_we       = 1'b1;
                        mem_wa       = idx_reg;
                        mem_wd       = key_reg;
                        cnt_next     = cnt_reg + 1'b1;
                        pend_ok_next = 1'b1;
                    end
                    state_next = hkse_pkg::ST_DONE;
                end
                else if (prb_reg == PRB_LAST)
                begin
                    state_next = hkse_pkg::ST_DONE;
                end
                else
                begin
                    prb_next   = prb_reg + 1'b1;
                    idx_next   = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                    state_next = hkse_pkg::ST_READ;
                end
            end
            hkse_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_ok_next      = pend_ok_reg;
                    rsp_entries_next = hkse_pkg::ENTRIES_W'(cnt_reg);
                    state_next       = hkse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hkse_pkg::ST_CLR;
            clr_idx_reg    <= '0;
            cnt_reg        <= '0;
            clr_report_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            cnt_reg        <= cnt_next;
            clr_report_reg <= clr_report_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        prb_reg         <= prb_next;
        pend_ok_reg     <= pend_ok_next;
        mod_sh_reg      <= mod_sh_next;
        mod_rem_reg     <= mod_rem_next;
        mod_cyc_reg     <= mod_cyc_next;
        rsp_ok_reg      <= rsp_ok_next;
        rsp_entries_reg <= rsp_entries_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_CAP)
        else $error("key count above capacity");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == hkse_pkg::ST_CLR || state_reg == hkse_pkg::ST_CHECK))
        else $error("slot write outside clear or check");

    a_insert_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == hkse_pkg::ST_CHECK) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("insert did not bump count");

    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != hkse_pkg::ST_IDLE)
        else $error("accepted word left fsm idle");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkse_pkg::ST_DONE && state_next == hkse_pkg::ST_IDLE) |=>
            rsp_valid_reg && rsp_entries_reg == hkse_pkg::ENTRIES_W'(cnt_reg))
        else $error("result not registered on completion");

endmodule
